// ----- hdl/sfv_pkg.sv -----
// Shared types and constants for the spectrum frame line validator.
// No dependencies; imported by every module under hdl.
`timescale 1ns / 1ps

package sfv_pkg;

  // Largest point count a header may announce
  localparam int unsigned MAX_POINTS = 1024;
  // Width of the point counters, wide enough to hold MAX_POINTS itself
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);

  typedef enum logic [1:0] {
    FUNC_HDR   = 2'd0,
    FUNC_END   = 2'd1,
    FUNC_POINT = 2'd2,
    FUNC_OTHER = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_COLLECT = 2'd0,
    ST_READY   = 2'd1,
    ST_ERROR   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_BAD_HDR    = 3'd1,
    ERR_CNT_RANGE  = 3'd2,
    ERR_MISMATCH   = 3'd3,
    ERR_TOO_MANY   = 3'd4,
    ERR_BAD_POINT  = 3'd5,
    ERR_NOT_CONTIG = 3'd6,
    ERR_UNEXPECTED = 3'd7
  } err_e;

  typedef struct packed {
    func_e       func;
    logic        fields_ok;
    logic [7:0]  hdr_group;
    logic [7:0]  hdr_replicate;
    logic [15:0] hdr_points;
    logic [15:0] pt_pixel;
    logic [15:0] pt_adc;
  } line_t;

  typedef struct packed {
    status_e            status;
    err_e               err_code;
    logic               sample_valid;
    logic [9:0]         sample_index;
    logic signed [15:0] sample_value;
    logic [15:0]        frame_first_pixel;
    logic [7:0]         frame_group;
    logic [7:0]         frame_replicate;
    logic [10:0]        frame_points;
  } result_t;

endpackage

// ----- hdl/spectrum_frame_line_validator_top.sv -----
// A line request accepted into the line register is checked combinationally in sfv_core,
// and its result is loaded into the result register, which drives out_o.
// Throughput: one line per cycle; the line register refills as the result
// register loads, so only a stalled consumer holds off new requests.
// Reset (rst_ni, asynchronous, active low) empties both registers and clears
// the frame state: not collecting, counts, first pixel and IDs at zero.
// Depends on sfv_pkg, sfv_in_reg, sfv_core, sfv_out_reg.
`timescale 1ns / 1ps

module spectrum_frame_line_validator_top
  import sfv_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  line_t   in_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_o
);

  logic    line_valid;
  logic    res_ready;
  logic    fire;
  line_t   line;
  result_t res;

  assign fire = line_valid && res_ready;

  sfv_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_i),
    .line_valid_o (line_valid),
    .line_take_i  (fire),
    .line_o       (line)
  );

  sfv_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .line_i   (line),
    .result_o (res)
  );

  sfv_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (line_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_o)
  );

endmodule

// ----- hdl/sfv_in_reg.sv -----
// Input register stage: holds one tokenised line request for the checker.
// Depends on sfv_pkg.
`timescale 1ns / 1ps

module sfv_in_reg
  import sfv_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  line_t in_data_i,
  output logic  line_valid_o,
  input  logic  line_take_i,
  output line_t line_o
);

  logic  valid_q, valid_d;
  line_t data_q;

  // Refill in the same cycle the held request moves on
  assign in_ready_o = !valid_q || line_take_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

  assign line_valid_o = valid_q;
  assign line_o       = data_q;

endmodule

// ----- hdl/sfv_core.sv -----
// Frame state and per-line checks; one line is resolved each time it fires.
// Depends on sfv_pkg.
`timescale 1ns / 1ps

module sfv_core
  import sfv_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  line_t   line_i,
  output result_t result_o
);

  logic             collecting_q, collecting_d;
  logic [CNT_W-1:0] exp_q, exp_d;
  logic [CNT_W-1:0] recv_q, recv_d;
  logic [15:0]      first_pix_q, first_pix_d;
  logic [7:0]       group_q, group_d;
  logic [7:0]       repl_q, repl_d;

  logic        pts_bad;
  logic [15:0] pix_expect;
  result_t     res;

  assign pts_bad    = (line_i.hdr_points == 16'd0) ||
                      ({1'b0, line_i.hdr_points} > 17'(MAX_POINTS));
  assign pix_expect = 16'(first_pix_q + 16'(recv_q));

  always_comb begin
    collecting_d = collecting_q;
    exp_d        = exp_q;
    recv_d       = recv_q;
    first_pix_d  = first_pix_q;
    group_d      = group_q;
    repl_d       = repl_q;
    res          = '0;
    res.status   = ST_COLLECT;
    res.err_code = ERR_NONE;

    if (line_i.func == FUNC_HDR) begin
      if (!line_i.fields_ok || pts_bad) begin
        res.status   = ST_ERROR;
        res.err_code = !line_i.fields_ok ? ERR_BAD_HDR : ERR_CNT_RANGE;
        collecting_d = 1'b0;
        exp_d        = '0;
        recv_d       = '0;
      end else begin
        group_d      = line_i.hdr_group;
        repl_d       = line_i.hdr_replicate;
        exp_d        = CNT_W'(line_i.hdr_points);
        recv_d       = '0;
        first_pix_d  = '0;
        collecting_d = 1'b1;
      end
    end else if (!collecting_q) begin
      res.status   = ST_ERROR;
      res.err_code = ERR_UNEXPECTED;
    end else begin
      // every remaining outcome closes the frame unless a sample is taken
      collecting_d = 1'b0;
      exp_d        = '0;
      recv_d       = '0;
      if (line_i.func == FUNC_END) begin
        if (recv_q != exp_q) begin
          res.status   = ST_ERROR;
          res.err_code = ERR_MISMATCH;
        end else begin
          res.status            = ST_READY;
          res.frame_first_pixel = first_pix_q;
          res.frame_group       = group_q;
          res.frame_replicate   = repl_q;
          res.frame_points      = 11'(recv_q);
        end
      end else if (recv_q >= exp_q) begin
        res.status   = ST_ERROR;
        res.err_code = ERR_TOO_MANY;
      end else if (line_i.func == FUNC_OTHER || !line_i.fields_ok) begin
        res.status   = ST_ERROR;
        res.err_code = ERR_BAD_POINT;
      end else if (recv_q != '0 && line_i.pt_pixel != pix_expect) begin
        res.status   = ST_ERROR;
        res.err_code = ERR_NOT_CONTIG;
      end else begin
        if (recv_q == '0) begin
          first_pix_d = line_i.pt_pixel;
        end
        res.sample_valid = 1'b1;
        res.sample_index = 10'(recv_q);
        res.sample_value = line_i.pt_adc;
        collecting_d     = 1'b1;
        exp_d            = exp_q;
        recv_d           = CNT_W'(recv_q + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      collecting_q <= 1'b0;
      exp_q        <= '0;
      recv_q       <= '0;
      first_pix_q  <= '0;
      group_q      <= '0;
      repl_q       <= '0;
    end else if (fire_i) begin
      collecting_q <= collecting_d;
      exp_q        <= exp_d;
      recv_q       <= recv_d;
      first_pix_q  <= first_pix_d;
      group_q      <= group_d;
      repl_q       <= repl_d;
    end
  end

  assign result_o = res;

  a_open_frame_bounds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    collecting_q |-> (exp_q != '0 && recv_q <= exp_q))
    else $error("open frame with count out of bounds");

  a_idle_counts_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !collecting_q |-> (exp_q == '0 && recv_q == '0))
    else $error("counts not cleared while idle");

  a_sample_bumps_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && res.sample_valid) |=> (recv_q == CNT_W'($past(recv_q) + 1'b1)))
    else $error("accepted sample did not advance the count");

  a_ready_closes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && res.status != ST_COLLECT) |=> !collecting_q)
    else $error("frame still open after ready or error");

endmodule

// ----- hdl/sfv_out_reg.sv -----
// Result register: holds one result request until the consumer takes it.
// Depends on sfv_pkg.
`timescale 1ns / 1ps

module sfv_out_reg
  import sfv_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    res_valid_i,
  output logic    res_ready_o,
  input  result_t res_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_data_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  assign res_ready_o = !valid_q || out_ready_i;
  assign valid_d     = res_ready_o ? res_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ----- tb/spectrum_frame_line_validator_top_tb.sv -----
// Self-checking testbench for spectrum_frame_line_validator_top: drives tokenised
// lines over valid/ready and checks every result against a frame-state predictor.
// Depends on sfv_pkg and the RTL under hdl.
`timescale 1ns / 1ps

module spectrum_frame_line_validator_top_tb;
  import sfv_pkg::*;

  localparam int LINE_W = $bits(line_t);

  typedef enum int {
    FLAW_NONE,
    FLAW_PIXEL,
    FLAW_FIELDS,
    FLAW_OTHER,
    FLAW_EXTRA,
    FLAW_SHORT,
    FLAW_RESTART
  } flaw_e;

  // Tracks the frame state and queues the result each accepted line should give
  class frame_scoreboard;
    bit                 collecting;
    logic [CNT_W-1:0]   exp_cnt;
    logic [CNT_W-1:0]   rcv_cnt;
    logic [15:0]        first_pix;
    logic [7:0]         grp;
    logic [7:0]         rep;
    result_t            pending_q[$];
    int                 n_lines;
    int                 n_results;
    int                 n_ready;
    int                 n_err;
    int                 n_fail;

    function new();
      collecting = 1'b0;
      exp_cnt    = '0;
      rcv_cnt    = '0;
      first_pix  = '0;
      grp        = '0;
      rep        = '0;
    endfunction

    function result_t abort_frame(err_e code);
      result_t r;
      collecting = 1'b0;
      exp_cnt    = '0;
      rcv_cnt    = '0;
      r          = '0;
      r.status   = ST_ERROR;
      r.err_code = code;
      return r;
    endfunction

    function result_t predict_result(line_t l);
      result_t     r;
      logic [15:0] next_pix;
      r          = '0;
      r.status   = ST_COLLECT;
      r.err_code = ERR_NONE;
      next_pix   = first_pix + 16'(rcv_cnt);
      if (l.func == FUNC_HDR) begin
        if (!l.fields_ok) begin
          r = abort_frame(ERR_BAD_HDR);
        end else if (l.hdr_points == 16'd0 || l.hdr_points > MAX_POINTS) begin
          r = abort_frame(ERR_CNT_RANGE);
        end else begin
          // a header always restarts the frame
          grp        = l.hdr_group;
          rep        = l.hdr_replicate;
          exp_cnt    = l.hdr_points[CNT_W-1:0];
          rcv_cnt    = '0;
          first_pix  = '0;
          collecting = 1'b1;
        end
      end else if (!collecting) begin
        // state left alone
        r.status   = ST_ERROR;
        r.err_code = ERR_UNEXPECTED;
      end else if (l.func == FUNC_END) begin
        if (rcv_cnt != exp_cnt) begin
          r = abort_frame(ERR_MISMATCH);
        end else begin
          r.status            = ST_READY;
          r.frame_first_pixel = first_pix;
          r.frame_group       = grp;
          r.frame_replicate   = rep;
          r.frame_points      = rcv_cnt;
          collecting = 1'b0;
          exp_cnt    = '0;
          rcv_cnt    = '0;
        end
      end else if (rcv_cnt >= exp_cnt) begin
        r = abort_frame(ERR_TOO_MANY);
      end else if (l.func == FUNC_OTHER || !l.fields_ok) begin
        r = abort_frame(ERR_BAD_POINT);
      end else if (rcv_cnt != '0 && l.pt_pixel != next_pix) begin
        r = abort_frame(ERR_NOT_CONTIG);
      end else begin
        if (rcv_cnt == '0) begin
          first_pix = l.pt_pixel;
        end
        r.sample_valid = 1'b1;
        r.sample_index = rcv_cnt[9:0];
        r.sample_value = l.pt_adc;
        rcv_cnt        = rcv_cnt + 1'b1;
      end
      return r;
    endfunction

    function void note_line(line_t l);
      pending_q.push_back(predict_result(l));
      n_lines++;
    endfunction

    function void check_result(result_t a);
      result_t e;
      n_results++;
      if (pending_q.size() == 0) begin
        $error("result with no line pending: status %0d err_code %0d", a.status, a.err_code);
        n_fail++;
        return;
      end
      e = pending_q.pop_front();
      if (e.status == ST_READY) n_ready++;
      if (e.status == ST_ERROR) n_err++;
      if (a.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, a.status);
        n_fail++;
      end
      if (a.err_code !== e.err_code) begin
        $error("err_code: expected %0d, got %0d", e.err_code, a.err_code);
        n_fail++;
      end
      if (a.sample_valid !== e.sample_valid) begin
        $error("sample_valid: expected %0d, got %0d", e.sample_valid, a.sample_valid);
        n_fail++;
      end
      if (a.sample_index !== e.sample_index) begin
        $error("sample_index: expected %0d, got %0d", e.sample_index, a.sample_index);
        n_fail++;
      end
      if (a.sample_value !== e.sample_value) begin
        $error("sample_value: expected %0d, got %0d", e.sample_value, a.sample_value);
        n_fail++;
      end
      if (a.frame_first_pixel !== e.frame_first_pixel) begin
        $error("frame_first_pixel: expected %0h, got %0h",
               e.frame_first_pixel, a.frame_first_pixel);
        n_fail++;
      end
      if (a.frame_group !== e.frame_group) begin
        $error("frame_group: expected %0h, got %0h", e.frame_group, a.frame_group);
        n_fail++;
      end
      if (a.frame_replicate !== e.frame_replicate) begin
        $error("frame_replicate: expected %0h, got %0h", e.frame_replicate, a.frame_replicate);
        n_fail++;
      end
      if (a.frame_points !== e.frame_points) begin
        $error("frame_points: expected %0d, got %0d", e.frame_points, a.frame_points);
        n_fail++;
      end
    endfunction

    function int pending();
      return pending_q.size();
    endfunction
  endclass

  logic    clk_i       = 1'b0;
  logic    rst_ni      = 1'b0;
  logic    in_valid_i  = 1'b0;
  logic    in_ready_o;
  line_t   in_i        = '0;
  logic    out_valid_o;
  logic    out_ready_i = 1'b0;
  result_t out_o;

  frame_scoreboard sb = new();
  int snd_idle  = 0;
  int rcv_idle  = 0;
  int hold_req  = 0;
  int line_cnt  = 0;

  spectrum_frame_line_validator_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #(5_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: check on each accepted result, then pick next cycle's ready
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_ready_i) begin
        sb.check_result(out_o);
      end
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  task automatic send_line(input line_t l);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < snd_idle) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= l;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    sb.note_line(l);
    line_cnt++;
  endtask

  // Unused fields of every line carry random bits
  task automatic send_hdr(input logic ok, input logic [15:0] pts);
    line_t l;
    l               = line_t'(LINE_W'({$urandom, $urandom, $urandom}));
    l.func          = FUNC_HDR;
    l.fields_ok     = ok;
    l.hdr_points    = pts;
    send_line(l);
  endtask

  task automatic send_pt(input func_e f, input logic ok, input logic [15:0] pix,
                         input logic [15:0] adc);
    line_t l;
    l           = line_t'(LINE_W'({$urandom, $urandom, $urandom}));
    l.func      = f;
    l.fields_ok = ok;
    l.pt_pixel  = pix;
    l.pt_adc    = adc;
    send_line(l);
  endtask

  task automatic send_noise();
    send_line(line_t'(LINE_W'({$urandom, $urandom, $urandom})));
  endtask

  // Sender pause: drop valid and let every outstanding result come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_frame(input int n, input flaw_e flaw);
    logic [15:0] pix;
    int          where;
    int          last;
    pix   = 16'($urandom);
    if ($urandom_range(3) == 0) pix = 16'hFFFF - 16'($urandom_range(0, n));
    where = $urandom_range(0, n - 1);
    last  = (flaw == FLAW_SHORT) ? n - 1 : n;
    send_hdr(1'b1, 16'(n));
    for (int k = 0; k < last; k++) begin
      if (k == where && flaw inside {FLAW_PIXEL, FLAW_FIELDS, FLAW_OTHER, FLAW_RESTART}) begin
        case (flaw)
          FLAW_PIXEL:  send_pt(FUNC_POINT, 1'b1, pix + 16'(k) + 16'($urandom_range(1, 100)),
                               16'($urandom));
          FLAW_FIELDS: send_pt(FUNC_POINT, 1'b0, pix + 16'(k), 16'($urandom));
          FLAW_OTHER:  send_pt(FUNC_OTHER, 1'($urandom), pix + 16'(k), 16'($urandom));
          default:     send_hdr(1'b1, 16'($urandom_range(1, 8)));
        endcase
        // rest of the frame dropped; a stray end marker sometimes follows
        if ($urandom_range(1) == 0) send_pt(FUNC_END, 1'($urandom), 16'($urandom), 16'($urandom));
        return;
      end
      send_pt(FUNC_POINT, 1'b1, pix + 16'(k), 16'($urandom));
    end
    if (flaw == FLAW_EXTRA) begin
      send_pt($urandom_range(1) ? FUNC_POINT : FUNC_OTHER, 1'($urandom), pix + 16'(n),
              16'($urandom));
    end
    send_pt(FUNC_END, 1'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic run_random(input int target);
    int    pick;
    int    n;
    flaw_e flaw;
    while (line_cnt < target) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        send_noise();
      end else if (pick < 10) begin
        if ($urandom_range(1) == 0) send_hdr(1'b0, 16'($urandom));
        else send_hdr(1'b1, 16'($urandom_range(MAX_POINTS + 1, 65535)));
      end else begin
        pick = $urandom_range(99);
        if (pick < 70)      n = $urandom_range(1, 8);
        else if (pick < 95) n = $urandom_range(9, 48);
        else                n = $urandom_range(49, 200);
        flaw = ($urandom_range(99) < 65) ? FLAW_NONE : flaw_e'($urandom_range(1, 6));
        run_frame(n, flaw);
      end
    end
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // lines while idle, malformed and out-of-range headers
    snd_idle = 0;
    rcv_idle = 0;
    send_pt(FUNC_END, 1'b1, 16'h0000, 16'h0000);
    send_pt(FUNC_POINT, 1'b1, 16'h0000, 16'h0000);
    send_pt(FUNC_OTHER, 1'b0, 16'hFFFF, 16'hFFFF);
    send_hdr(1'b0, 16'd4);
    send_hdr(1'b1, 16'd0);
    send_hdr(1'b1, 16'(MAX_POINTS + 1));
    // one-point frame at the top pixel, then a two-point frame wrapping past it
    send_hdr(1'b1, 16'd1);
    send_pt(FUNC_POINT, 1'b1, 16'hFFFF, 16'h8000);
    send_pt(FUNC_END, 1'b1, 16'h0000, 16'h0000);
    send_hdr(1'b1, 16'd2);
    send_pt(FUNC_POINT, 1'b1, 16'hFFFF, 16'h7FFF);
    send_pt(FUNC_POINT, 1'b1, 16'h0000, 16'hFFFF);
    send_pt(FUNC_END, 1'b0, 16'h0000, 16'h0000);
    // largest count closed early, one point too many, bad point, gap in pixels
    send_hdr(1'b1, 16'(MAX_POINTS));
    send_pt(FUNC_END, 1'b1, 16'h0000, 16'h0000);
    send_hdr(1'b1, 16'd1);
    send_pt(FUNC_POINT, 1'b1, 16'd5, 16'd0);
    send_pt(FUNC_POINT, 1'b1, 16'd6, 16'd0);
    send_hdr(1'b1, 16'd2);
    send_pt(FUNC_POINT, 1'b0, 16'd7, 16'd1);
    send_hdr(1'b1, 16'd3);
    send_pt(FUNC_POINT, 1'b1, 16'd10, 16'd1);
    send_pt(FUNC_POINT, 1'b1, 16'd12, 16'd1);
    // header mid-frame restarts it
    send_hdr(1'b1, 16'd2);
    send_pt(FUNC_POINT, 1'b1, 16'd20, 16'd2);
    send_hdr(1'b1, 16'd1);
    send_pt(FUNC_POINT, 1'b1, 16'd30, 16'd3);
    send_pt(FUNC_END, 1'b1, 16'h0000, 16'h0000);
    drain();

    // slow consumer; a long hold-off early on backs the block up
    snd_idle = 10;
    rcv_idle = 62;
    hold_req = 300;
    run_frame(20, FLAW_NONE);
    run_random(240);
    drain();

    snd_idle = 62;
    rcv_idle = 10;
    run_random(440);
    drain();

    snd_idle = 0;
    rcv_idle = 0;
    run_frame(MAX_POINTS, FLAW_NONE);
    run_random(line_cnt + 40);
    drain();
    repeat (10) @(posedge clk_i);

    $display("Run covered %0d line requests and %0d results (%0d frames ready, %0d errors).",
             sb.n_lines, sb.n_results, sb.n_ready, sb.n_err);
    if (sb.n_fail == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
